FILE: hdl/sis_pkg.sv
// Package for the sorted integer set unit: codes, sizes and item types.
`default_nettype none
package sis_pkg;

	// Default number of entries in the store
	localparam int CAPACITY_DEF = 64;

	// Field widths fixed by the item format
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int KEY_W   = 31;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	// Input item
	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               found;
		logic [COUNT_W-1:0] count;
	} out_item_t;

endpackage
`default_nettype wire

FILE: hdl/sorted_integer_set_unit.sv
// Sorted integer set unit: top level with search/shift sequencer and entry store.
//
// Keeps up to CAPACITY distinct non-negative keys in ascending order in a
// single-port-write, single-port-read memory. An item is taken when start is
// high and busy is low; busy then stays high until the result is emitted.
// The result shows for exactly one cycle with done high and cannot be held
// off, so the receiver must take it on that cycle. All work runs through one
// memory read port and one 31-bit comparator: a lookup walks the stored
// entries one per cycle from the bottom up to the first entry not below the
// key, then an add moves every larger entry up one slot and a remove moves
// every entry above the hit down one slot, again one entry per cycle. Walk
// and move together touch each stored entry about once, so the time until
// done grows with the number of entries stored; a negative key skips the
// walk. A new item can be started in the cycle that done is high.
// The store needs no clearing after reset.
`default_nettype none
module sorted_integer_set_unit #(
	parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sis_pkg::in_item_t request,
	output logic                   done,
	output sis_pkg::out_item_t     result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_PLACE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Item registers
	logic [sis_pkg::CMD_W-1:0]  cmd_q;
	logic [sis_pkg::KEY_W-1:0]  key_q;
	logic                       neg_q;
	logic [sis_pkg::STAT_W-1:0] stat_q;
	logic                       present_q;
	logic [CW-1:0]              pos_q;

	// Set size
	logic [CW-1:0] count_q;

	// Walk control: read pointer, outstanding read and its index
	logic [CW-1:0] rd_ptr_q;
	logic          rd_vld_q;
	logic [CW-1:0] rd_idx_q;
	logic          iss_q;

	// Entry store
	logic [sis_pkg::KEY_W-1:0] mem [CAPACITY];
	logic [sis_pkg::KEY_W-1:0] rdata_q;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      we;
	logic [AW-1:0]             wr_addr;
	logic [sis_pkg::KEY_W-1:0] wr_data;

	logic hit;
	logic search_issue;

	assign busy = (state_q != ST_IDLE);

	// Lookup compare: first entry not below the key
	assign hit          = rd_vld_q && (rdata_q >= key_q);
	assign search_issue = (state_q == ST_SEARCH) && (rd_ptr_q < count_q) && !hit;

	// Memory port control
	always_comb begin
		rd_en   = search_issue ||
		          (((state_q == ST_SHIFT_UP) || (state_q == ST_SHIFT_DN)) && iss_q);
		rd_addr = rd_ptr_q[AW-1:0];
		we      = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = key_q;
		unique case (state_q)
			ST_SHIFT_UP: begin
				we      = rd_vld_q;
				wr_addr = AW'(rd_idx_q + ONE_C);
				wr_data = rdata_q;
			end
			ST_SHIFT_DN: begin
				we      = rd_vld_q;
				wr_addr = AW'(rd_idx_q - ONE_C);
				wr_data = rdata_q;
			end
			ST_PLACE: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Entry store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_vld_q  <= 1'b0;
			iss_q     <= 1'b0;
			done      <= 1'b0;
			cmd_q     <= '0;
			key_q     <= '0;
			neg_q     <= 1'b0;
			stat_q    <= '0;
			present_q <= 1'b0;
			pos_q     <= '0;
			rd_ptr_q  <= '0;
			rd_idx_q  <= '0;
			result    <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q     <= request.command;
						key_q     <= request.value[sis_pkg::KEY_W-1:0];
						neg_q     <= request.value[sis_pkg::VALUE_W-1];
						present_q <= 1'b0;
						pos_q     <= '0;
						rd_ptr_q  <= '0;
						rd_vld_q  <= 1'b0;
						state_q   <= request.value[sis_pkg::VALUE_W-1] ? ST_DECIDE : ST_SEARCH;
					end
				end

				// Walk up from entry 0 until an entry >= key or the end
				ST_SEARCH: begin
					if (hit) begin
						pos_q     <= rd_idx_q;
						present_q <= (rdata_q == key_q);
						rd_vld_q  <= 1'b0;
						state_q   <= ST_DECIDE;
					end else if (!rd_vld_q && (rd_ptr_q >= count_q)) begin
						pos_q     <= count_q;
						present_q <= 1'b0;
						state_q   <= ST_DECIDE;
					end else begin
						rd_vld_q <= search_issue;
						rd_idx_q <= rd_ptr_q;
						if (search_issue) begin
							rd_ptr_q <= rd_ptr_q + ONE_C;
						end
					end
				end

				// Pick the action from command and lookup outcome
				ST_DECIDE: begin
					rd_vld_q <= 1'b0;
					state_q  <= ST_FINISH;
					stat_q   <= sis_pkg::STAT_DONE;
					unique case (cmd_q)
						sis_pkg::CMD_ADD: begin
							if (neg_q || present_q) begin
								stat_q <= sis_pkg::STAT_REJECT;
							end else if (count_q >= CAP_C) begin
								stat_q <= sis_pkg::STAT_FULL;
							end else if (pos_q == count_q) begin
								state_q <= ST_PLACE;
							end else begin
								rd_ptr_q <= count_q - ONE_C;
								iss_q    <= 1'b1;
								state_q  <= ST_SHIFT_UP;
							end
						end
						sis_pkg::CMD_REMOVE: begin
							if (neg_q || (count_q == '0) || !present_q) begin
								stat_q <= sis_pkg::STAT_REJECT;
							end else if ((pos_q + ONE_C) < count_q) begin
								rd_ptr_q <= pos_q + ONE_C;
								iss_q    <= 1'b1;
								state_q  <= ST_SHIFT_DN;
							end else begin
								count_q <= count_q - ONE_C;
							end
						end
						sis_pkg::CMD_FIND: begin
							stat_q <= sis_pkg::STAT_DONE;
						end
						default: begin
							stat_q <= sis_pkg::STAT_REJECT;
						end
					endcase
				end

				// Move entries count-1 down to pos up by one slot
				ST_SHIFT_UP: begin
					rd_vld_q <= iss_q;
					rd_idx_q <= rd_ptr_q;
					if (iss_q) begin
						if (rd_ptr_q == pos_q) begin
							iss_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q - ONE_C;
						end
					end else if (!rd_vld_q) begin
						state_q <= ST_PLACE;
					end
				end

				// Move entries pos+1 up to count-1 down by one slot
				ST_SHIFT_DN: begin
					rd_vld_q <= iss_q;
					rd_idx_q <= rd_ptr_q;
					if (iss_q) begin
						if (rd_ptr_q == (count_q - ONE_C)) begin
							iss_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q + ONE_C;
						end
					end else if (!rd_vld_q) begin
						count_q <= count_q - ONE_C;
						state_q <= ST_FINISH;
					end
				end

				// Write the new key into its slot
				ST_PLACE: begin
					count_q <= count_q + ONE_C;
					state_q <= ST_FINISH;
				end

				// Emit the result item
				ST_FINISH: begin
					done          <= 1'b1;
					result.status <= stat_q;
					result.found  <= present_q;
					result.count  <= sis_pkg::COUNT_W'(count_q);
					state_q       <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Set size never exceeds the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// A result only follows the finish step
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result without finish step");

	// Full status only when the store is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == sis_pkg::STAT_FULL)) |->
		(result.count == sis_pkg::COUNT_W'(CAPACITY)))
		else $error("full status with room left");

	// The store is never written while idle or searching
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) || (state_q == ST_SEARCH)) |-> !we)
		else $error("store written outside update steps");

	// An item changes the size by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=>
		((count_q == $past(count_q)) || (count_q == $past(count_q) + ONE_C) ||
		 (count_q == $past(count_q) - ONE_C)))
		else $error("entry count jumped");

endmodule
`default_nettype wire
